// ===== design/vbmd_pkg.sv =====
package vbmd_pkg;

  // Default store sizes in 1 KiB pages
  localparam int PATTERN_PAGES_DEF = 8;
  localparam int TABLE_PAGES_DEF   = 4;

  localparam int PAGE_BITS    = 10;
  localparam int ADDR_W       = 14;
  localparam int DATA_W       = 8;
  localparam int PAL_W        = 6;
  localparam int PAL_DEPTH    = 32;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [ADDR_W-1:0] TABLE_BASE   = 14'h2000;
  localparam logic [ADDR_W-1:0] PALETTE_BASE = 14'h3F00;
  localparam logic [DATA_W-1:0] GRAY_MASK    = 8'h30;
  localparam logic [DATA_W-1:0] FULL_MASK    = 8'hFF;

  // Register reset values
  localparam logic       GRAYSCALE_RST  = 1'b0;
  localparam logic [7:0] PATTERN_WE_RST = 8'h00;
  localparam logic [3:0] TABLE_WE_RST   = 4'hF;
  localparam logic [7:0] PAGE_MAP_RST   = 8'h44;

  typedef enum logic [1:0] {
    REGION_PATTERN = 2'd0,
    REGION_TABLE   = 2'd1,
    REGION_PALETTE = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    REG_GRAYSCALE  = 2'd0,
    REG_PATTERN_WE = 2'd1,
    REG_TABLE_WE   = 2'd2,
    REG_PAGE_MAP   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       grayscale;
    logic [7:0] pattern_we;
    logic [3:0] table_we;
    logic [7:0] page_map;
  } cfg_t;

  // Per-item control from the decoder to the stores and the result stage
  typedef struct packed {
    region_t region;
    logic    pat_we;
    logic    pat_re;
    logic    tab_we;
    logic    tab_re;
    logic    pal_we;
    logic    pal_re;
    logic    landed;
  } access_t;

  // Wrap a small page number into 0..pages-1 by repeated subtraction
  function automatic logic [2:0] page_wrap(logic [2:0] page, int pages);
    logic [3:0] v;
    logic [3:0] p;
    v = {1'b0, page};
    p = 4'(pages);
    for (int i = 0; i < 8; i++) begin
      if (v >= p) begin
        v = v - p;
      end
    end
    return v[2:0];
  endfunction

endpackage

// ===== design/vbmd_ram.sv =====
module vbmd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry; read data is registered and shows in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/vbmd_cfg.sv =====
module vbmd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vbmd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [vbmd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [vbmd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output vbmd_pkg::cfg_t                     cfg
);

  vbmd_pkg::cfg_t   cfg_r;
  vbmd_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = vbmd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Update the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grayscale  <= vbmd_pkg::GRAYSCALE_RST;
      cfg_r.pattern_we <= vbmd_pkg::PATTERN_WE_RST;
      cfg_r.table_we   <= vbmd_pkg::TABLE_WE_RST;
      cfg_r.page_map   <= vbmd_pkg::PAGE_MAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        vbmd_pkg::REG_GRAYSCALE:  cfg_r.grayscale  <= pwdata[0];
        vbmd_pkg::REG_PATTERN_WE: cfg_r.pattern_we <= pwdata[7:0];
        vbmd_pkg::REG_TABLE_WE:   cfg_r.table_we   <= pwdata[3:0];
        vbmd_pkg::REG_PAGE_MAP:   cfg_r.page_map   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      vbmd_pkg::REG_GRAYSCALE:  prdata = {31'd0, cfg_r.grayscale};
      vbmd_pkg::REG_PATTERN_WE: prdata = {24'd0, cfg_r.pattern_we};
      vbmd_pkg::REG_TABLE_WE:   prdata = {28'd0, cfg_r.table_we};
      vbmd_pkg::REG_PAGE_MAP:   prdata = {24'd0, cfg_r.page_map};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/vbmd_decode.sv =====
module vbmd_decode #(
  parameter int PATTERN_PAGES = vbmd_pkg::PATTERN_PAGES_DEF,
  parameter int TABLE_PAGES   = vbmd_pkg::TABLE_PAGES_DEF
) (
  input  logic                                      accept,
  input  logic                                      command,
  input  logic [vbmd_pkg::ADDR_W-1:0]               address,
  input  vbmd_pkg::cfg_t                            cfg,
  output vbmd_pkg::access_t                         acc,
  output logic [$clog2(PATTERN_PAGES*1024)-1:0]     pat_idx,
  output logic [$clog2(TABLE_PAGES*1024)-1:0]       tab_idx,
  output logic [4:0]                                pal_idx
);

  localparam int PW = $clog2(PATTERN_PAGES * 1024);
  localparam int TW = $clog2(TABLE_PAGES * 1024);

  logic [2:0]  lpage;
  logic [2:0]  ppage;
  logic [12:0] pat_full;
  logic [1:0]  win;
  logic [1:0]  sel;
  logic [2:0]  tpage;
  logic [11:0] tab_full;
  vbmd_pkg::region_t region;
  logic        wr;
  logic        rd;

  assign wr = accept && command;
  assign rd = accept && !command;

  // Pattern: identity paging, wrapped to the pages present
  assign lpage    = address[12:10];
  assign ppage    = vbmd_pkg::page_wrap(lpage, PATTERN_PAGES);
  assign pat_full = {ppage, address[vbmd_pkg::PAGE_BITS-1:0]};
  assign pat_idx  = pat_full[PW-1:0];

  // Name table: window picks a 2-bit page selector
  assign win      = address[11:10];
  assign sel      = cfg.page_map[{win, 1'b0} +: 2];
  assign tpage    = vbmd_pkg::page_wrap({1'b0, sel}, TABLE_PAGES);
  assign tab_full = {tpage[1:0], address[vbmd_pkg::PAGE_BITS-1:0]};
  assign tab_idx  = tab_full[TW-1:0];

  // Palette: entries on a multiple of four fold onto the backdrop and
  // read-back cells, which sit at 0, 4, 8 and C
  assign pal_idx = (address[1:0] == 2'b00) ? {1'b0, address[3:2], 2'b00} : address[4:0];

  always_comb begin
    if (address < vbmd_pkg::TABLE_BASE) begin
      region = vbmd_pkg::REGION_PATTERN;
    end else if (address < vbmd_pkg::PALETTE_BASE) begin
      region = vbmd_pkg::REGION_TABLE;
    end else begin
      region = vbmd_pkg::REGION_PALETTE;
    end
  end

  // Gate store strobes by region and write enables
  always_comb begin
    acc.region = region;
    acc.pat_we = wr && (region == vbmd_pkg::REGION_PATTERN) && cfg.pattern_we[lpage];
    acc.pat_re = rd && (region == vbmd_pkg::REGION_PATTERN);
    acc.tab_we = wr && (region == vbmd_pkg::REGION_TABLE) && cfg.table_we[win];
    acc.tab_re = rd && (region == vbmd_pkg::REGION_TABLE);
    acc.pal_we = wr && (region == vbmd_pkg::REGION_PALETTE);
    acc.pal_re = rd && (region == vbmd_pkg::REGION_PALETTE);
    acc.landed = acc.pat_we || acc.tab_we || acc.pal_we;
  end

endmodule

// ===== design/video_bus_memory_decoder_top.sv =====
// Channel   Handshake                     Payload
// input     start / busy                  in_command, in_address, in_write_data
// result    out_strobe (one cycle)        out_read_data, out_region,
//                                         out_write_landed, out_snoop_address
// config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// One item per clock: busy is low outside reset and a new item can be taken
// every cycle.
// Each result appears in the cycle after its item is taken, since the
// pattern, name-table and palette memories register their read data.
// Reset (rst_n low, synchronous) holds busy high, restores the registers and
// clears the result strobe; the stores hold no reset value and need no
// clearing pass.
// The receiver cannot stall, so no result is ever held back.
module video_bus_memory_decoder_top #(
  parameter int PATTERN_PAGES = vbmd_pkg::PATTERN_PAGES_DEF,
  parameter int TABLE_PAGES   = vbmd_pkg::TABLE_PAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [vbmd_pkg::ADDR_W-1:0]       in_address,
  input  logic [vbmd_pkg::DATA_W-1:0]       in_write_data,
  output logic                              out_strobe,
  output logic [vbmd_pkg::DATA_W-1:0]       out_read_data,
  output logic [1:0]                        out_region,
  output logic                              out_write_landed,
  output logic [vbmd_pkg::ADDR_W-1:0]       out_snoop_address,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vbmd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [vbmd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [vbmd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int PW = $clog2(PATTERN_PAGES * 1024);
  localparam int TW = $clog2(TABLE_PAGES * 1024);

  vbmd_pkg::cfg_t    cfg;
  vbmd_pkg::access_t acc;
  logic              accept;
  logic [PW-1:0]     pat_idx;
  logic [TW-1:0]     tab_idx;
  logic [4:0]        pal_idx;
  logic [vbmd_pkg::DATA_W-1:0] pat_rdata;
  logic [vbmd_pkg::DATA_W-1:0] tab_rdata;
  logic [vbmd_pkg::PAL_W-1:0]  pal_rdata;
  logic [vbmd_pkg::DATA_W-1:0] pal_byte;
  logic [vbmd_pkg::DATA_W-1:0] rd_byte;

  logic                        strobe_r;
  vbmd_pkg::region_t           region_r;
  logic                        landed_r;
  logic                        is_read_r;
  logic                        gray_r;
  logic [vbmd_pkg::ADDR_W-1:0] snoop_r;

  // Hold off items while reset is applied
  assign busy   = !rst_n;
  assign accept = start && !busy;

  vbmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vbmd_decode #(
    .PATTERN_PAGES (PATTERN_PAGES),
    .TABLE_PAGES   (TABLE_PAGES)
  ) u_decode (
    .accept  (accept),
    .command (in_command),
    .address (in_address),
    .cfg     (cfg),
    .acc     (acc),
    .pat_idx (pat_idx),
    .tab_idx (tab_idx),
    .pal_idx (pal_idx)
  );

  vbmd_ram #(
    .DEPTH (PATTERN_PAGES * 1024),
    .WIDTH (vbmd_pkg::DATA_W)
  ) u_pattern (
    .clk   (clk),
    .we    (acc.pat_we),
    .re    (acc.pat_re),
    .addr  (pat_idx),
    .wdata (in_write_data),
    .rdata (pat_rdata)
  );

  vbmd_ram #(
    .DEPTH (TABLE_PAGES * 1024),
    .WIDTH (vbmd_pkg::DATA_W)
  ) u_table (
    .clk   (clk),
    .we    (acc.tab_we),
    .re    (acc.tab_re),
    .addr  (tab_idx),
    .wdata (in_write_data),
    .rdata (tab_rdata)
  );

  vbmd_ram #(
    .DEPTH (vbmd_pkg::PAL_DEPTH),
    .WIDTH (vbmd_pkg::PAL_W)
  ) u_palette (
    .clk   (clk),
    .we    (acc.pal_we),
    .re    (acc.pal_re),
    .addr  (pal_idx),
    .wdata (in_write_data[vbmd_pkg::PAL_W-1:0]),
    .rdata (pal_rdata)
  );

  // Raise the result strobe in the cycle after the item is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
    end
  end

  // Hold the item's side information until its read data returns
  always_ff @(posedge clk) begin
    if (accept) begin
      region_r  <= acc.region;
      landed_r  <= acc.landed;
      is_read_r <= !in_command;
      gray_r    <= cfg.grayscale;
      snoop_r   <= in_address;
    end
  end

  // Select and mask the returned byte
  assign pal_byte = {2'b00, pal_rdata} &
                    (gray_r ? vbmd_pkg::GRAY_MASK : vbmd_pkg::FULL_MASK);

  always_comb begin
    case (region_r)
      vbmd_pkg::REGION_PATTERN: rd_byte = pat_rdata;
      vbmd_pkg::REGION_TABLE:   rd_byte = tab_rdata;
      vbmd_pkg::REGION_PALETTE: rd_byte = pal_byte;
      default:                  rd_byte = '0;
    endcase
  end

  assign out_strobe        = strobe_r;
  assign out_read_data     = is_read_r ? rd_byte : '0;
  assign out_region        = region_r;
  assign out_write_landed  = landed_r;
  assign out_snoop_address = snoop_r;

endmodule

// ===== design/vbmd_checker.sv =====
module vbmd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_command,
  input logic [vbmd_pkg::ADDR_W-1:0] in_address,
  input logic                        out_strobe,
  input logic [vbmd_pkg::DATA_W-1:0] out_read_data,
  input logic [1:0]                  out_region,
  input logic                        out_write_landed,
  input logic [vbmd_pkg::ADDR_W-1:0] out_snoop_address
);

  // One result for each item taken, in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(start && !busy && rst_n))
    else $error("result strobe does not follow the accepted item");

  // Snooped address is the one of the item that caused the result
  a_snoop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_snoop_address == $past(in_address))
    else $error("snoop address differs from the accepted address");

  // Only a write can land, and a write returns no data
  a_landed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_write_landed || out_read_data != 8'h00) |->
      ($past(in_command) == out_write_landed))
    else $error("landed flag or read data inconsistent with command");

  // Palette data is six bits wide
  a_pal_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_region == vbmd_pkg::REGION_PALETTE |-> out_read_data[7:6] == 2'b00)
    else $error("palette read data wider than six bits");

endmodule

bind video_bus_memory_decoder_top vbmd_checker u_vbmd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .in_address        (in_address),
  .out_strobe        (out_strobe),
  .out_read_data     (out_read_data),
  .out_region        (out_region),
  .out_write_landed  (out_write_landed),
  .out_snoop_address (out_snoop_address)
);
